@@ rtl/core/cwb_pkg.sv @@
// Shared types and constants for the coalescing write buffer.
// Holds the item and result structs used by the top level and its ports.
// No dependencies.
package cwb_pkg;

  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 32;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [DATA_W-1:0]  read_data;
    logic               coalesced;
    logic               evicted;
    logic [COUNT_W-1:0] write_back_count;
    logic [COUNT_W-1:0] coalesce_count;
  } out_t;

endpackage

@@ rtl/core/cwb_tag_array.sv @@
// Tag store of the write buffer: valid bits, block tags, age order and lookup.
// Finds the matching entry, the oldest entry and the slot a new block goes to.
// Depends on nothing but its parameters.
module cwb_tag_array #(
  parameter int ENTRIES = 8,
  parameter int TAG_W   = 26,
  parameter int IDX_W   = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [TAG_W-1:0] lookup_tag,
  input  logic             write_en,
  output logic             hit,
  output logic [IDX_W-1:0] hit_idx,
  output logic             full,
  output logic [IDX_W-1:0] slot_idx
);

  logic [ENTRIES-1:0] entry_valid;
  logic [TAG_W-1:0]   entry_tag [ENTRIES];
  // older[i][j] is set when entry i was last written before entry j.
  logic [ENTRIES-1:0] older [ENTRIES];

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] oldest_cand;
  logic [IDX_W-1:0]   lru_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   touch_idx;

  always_comb begin
    match       = '0;
    oldest_cand = '0;
    hit_idx     = '0;
    lru_idx     = '0;
    free_idx    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]       = entry_valid[i] && (entry_tag[i] == lookup_tag);
      oldest_cand[i] = 1'b1;
      for (int j = 0; j < ENTRIES; j++) begin
        if (j != i) begin
          oldest_cand[i] = oldest_cand[i] & older[i][j];
        end
      end
    end
    // Scanning downward leaves the lowest qualifying index in each result.
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (oldest_cand[i]) begin
        lru_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit  = |match;
    full = &entry_valid;
    // When full, the only slot freed by eviction is the oldest one.
    slot_idx  = full ? lru_idx : free_idx;
    touch_idx = hit ? hit_idx : slot_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        older[i] <= '0;
      end
    end else if (write_en) begin
      if (!hit) begin
        entry_valid[slot_idx] <= 1'b1;
        entry_tag[slot_idx]   <= lookup_tag;
      end
      for (int j = 0; j < ENTRIES; j++) begin
        if (IDX_W'(j) != touch_idx) begin
          older[j][touch_idx] <= 1'b1;
          older[touch_idx][j] <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/cwb_data_ram.sv @@
// Byte storage of the write buffer: one row of block bytes per entry.
// Byte-lane write with a whole-row clear on allocation; registered byte read.
// Depends on nothing but its parameters.
module cwb_data_ram #(
  parameter int ENTRIES     = 8,
  parameter int OFFSET_BITS = 6,
  parameter int IDX_W       = 3
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic                   wr_fill,
  input  logic [IDX_W-1:0]       wr_row,
  input  logic [OFFSET_BITS-1:0] wr_off,
  input  logic [7:0]             wr_data,
  input  logic                   rd_en,
  input  logic [IDX_W-1:0]       rd_row,
  input  logic [OFFSET_BITS-1:0] rd_off,
  output logic [7:0]             rd_byte
);

  localparam int BLOCK_BYTES = 1 << OFFSET_BITS;

  logic [BLOCK_BYTES-1:0][7:0] mem [ENTRIES];

  // An allocation writes every lane of the row: zeros except the new byte.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < BLOCK_BYTES; b++) begin
        if (OFFSET_BITS'(b) == wr_off) begin
          mem[wr_row][b] <= wr_data;
        end else if (wr_fill) begin
          mem[wr_row][b] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_byte <= mem[rd_row][rd_off];
    end else begin
      rd_byte <= '0;
    end
  end

endmodule

@@ rtl/core/coalescing_write_buffer_core.sv @@
// Top level of the coalescing write buffer: item register, statistics, result.
// Depends on cwb_pkg, cwb_tag_array and cwb_data_ram.
//
// Usage:
//   An item (kind, address, write_data) is taken at a rising edge with start
//   high and busy low. busy is always low, so one item can enter every cycle.
//   The item is registered, looked up against all entries and applied in the
//   following cycle; its result is on result with done high for exactly one
//   cycle, from the next edge on, held in the result registers. Throughput
//   is one item per cycle; the limit is the combinational tag compare and
//   age-order select across all entries, plus one write port on the byte
//   storage.
//   A read returns hit and the stored byte; a write merges into a matching
//   block or allocates one, dropping the least recently written block when
//   all entries are in use. Results carry the running eviction and merge
//   counts, both wrapping at 32 bits.
//   Reset empties the buffer and clears both counts; no sweep is needed since
//   every allocation clears its whole row. The receiver cannot stall: each
//   result is valid for its one cycle only.
module coalescing_write_buffer_core #(
  parameter int ENTRIES     = 8,
  parameter int OFFSET_BITS = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cwb_pkg::in_t  item,
  output logic          done,
  output cwb_pkg::out_t result
);

  import cwb_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TAG_W = ADDR_W - OFFSET_BITS;

  logic               s1_valid;
  in_t                s1_item;

  logic [TAG_W-1:0]       lookup_tag;
  logic [OFFSET_BITS-1:0] lookup_off;
  logic                   is_write;
  logic                   write_en;
  logic                   hit;
  logic                   full;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       slot_idx;
  logic                   coalesce_now;
  logic                   evict_now;

  logic [COUNT_W-1:0] write_back_total;
  logic [COUNT_W-1:0] coalesce_total;
  logic               res_hit;
  logic               res_coalesced;
  logic               res_evicted;
  logic [DATA_W-1:0]  rd_byte;

  assign busy = 1'b0;

  assign lookup_tag   = s1_item.address[ADDR_W-1:OFFSET_BITS];
  assign lookup_off   = s1_item.address[OFFSET_BITS-1:0];
  assign is_write     = (s1_item.kind == KIND_WRITE);
  assign write_en     = s1_valid && is_write;
  assign coalesce_now = write_en && hit;
  assign evict_now    = write_en && !hit && full;

  cwb_tag_array #(
    .ENTRIES(ENTRIES),
    .TAG_W  (TAG_W),
    .IDX_W  (IDX_W)
  ) u_tags (
    .clk       (clk),
    .rst       (rst),
    .lookup_tag(lookup_tag),
    .write_en  (write_en),
    .hit       (hit),
    .hit_idx   (hit_idx),
    .full      (full),
    .slot_idx  (slot_idx)
  );

  cwb_data_ram #(
    .ENTRIES    (ENTRIES),
    .OFFSET_BITS(OFFSET_BITS),
    .IDX_W      (IDX_W)
  ) u_data (
    .clk    (clk),
    .wr_en  (write_en),
    .wr_fill(!hit),
    .wr_row (hit ? hit_idx : slot_idx),
    .wr_off (lookup_off),
    .wr_data(s1_item.write_data),
    .rd_en  (s1_valid && !is_write && hit),
    .rd_row (hit_idx),
    .rd_off (lookup_off),
    .rd_byte(rd_byte)
  );

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_item <= item;
    end
    res_hit       <= hit;
    res_coalesced <= coalesce_now;
    res_evicted   <= evict_now;
    if (rst) begin
      s1_valid         <= 1'b0;
      done             <= 1'b0;
      write_back_total <= '0;
      coalesce_total   <= '0;
    end else begin
      s1_valid <= start && !busy;
      done     <= s1_valid;
      if (evict_now) begin
        write_back_total <= write_back_total + COUNT_W'(1);
      end
      if (coalesce_now) begin
        coalesce_total <= coalesce_total + COUNT_W'(1);
      end
    end
  end

  // The totals registers already hold the counts after the item being shown.
  always_comb begin
    result.hit              = res_hit;
    result.read_data        = rd_byte;
    result.coalesced        = res_coalesced;
    result.evicted          = res_evicted;
    result.write_back_count = write_back_total;
    result.coalesce_count   = coalesce_total;
  end

endmodule
